// ===== rtl/u8u16_pkg.sv =====
`timescale 1ns / 1ps

package u8u16_pkg;

   // Error status codes carried on end results
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;

   // Register map (byte addresses)
   localparam logic CSR_MAX_UNITS_ADDR = 1'b0;
   localparam logic [15:0] MAX_UNITS_RESET = 16'd255;

   // Code point and surrogate constants
   localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;
   localparam logic [15:0] HIGH_SURROGATE     = 16'hD800;
   localparam logic [15:0] LOW_SURROGATE      = 16'hDC00;

   // Result queue holds up to one surrogate pair
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_of_input;
      logic        is_end;
      logic [1:0]  status;
      logic [15:0] unit_count;
   } result_type;

   typedef struct packed {
      logic [20:0] code_point_acc;
      logic [1:0]  bytes_remaining;
      logic [15:0] units_written;
      logic [1:0]  error_status;
   } string_state_type;

endpackage

// ===== rtl/u8u16_decode.sv =====
`timescale 1ns / 1ps

module u8u16_decode import u8u16_pkg::*; (
   input  logic [7:0]       byte_in,
   input  logic [15:0]      max_units,
   input  string_state_type state_cur,
   output string_state_type state_nxt,
   output logic [1:0]       result_count,
   output result_type       result_first,
   output result_type       result_second
);

   string_state_type state_a;
   logic             emit_en;
   logic [20:0]      emit_cp;
   logic [20:0]      acc_shift;
   logic [20:0]      cp_offset;
   logic [16:0]      units_plus_two;
   result_type       end_result;
   result_type       emit_first;

   assign acc_shift      = {state_cur.code_point_acc[14:0], byte_in[5:0]};
   assign cp_offset      = emit_cp - SUPPLEMENTARY_BASE;
   assign units_plus_two = {1'b0, state_cur.units_written} + 17'd2;

   // Byte classification: lead, continuation, terminator
   always_comb begin
      state_a    = state_cur;
      emit_en    = 1'b0;
      emit_cp    = '0;
      end_result = '0;
      if (byte_in == 8'h00) begin
         // end of string: report status and count, then clear
         end_result.last_of_input = 1'b1;
         end_result.is_end        = 1'b1;
         if (state_cur.bytes_remaining != 2'd0 && state_cur.error_status == ST_OK) begin
            end_result.status = ST_MALFORMED;
         end else begin
            end_result.status = state_cur.error_status;
         end
         if (end_result.status == ST_OK) begin
            end_result.unit_count = state_cur.units_written;
         end
         state_a = '0;
      end else if (state_cur.error_status != ST_OK) begin
         // swallow bytes until terminator
      end else if (state_cur.bytes_remaining != 2'd0) begin
         if (byte_in[7:6] != 2'b10) begin
            state_a.error_status    = ST_MALFORMED;
            state_a.bytes_remaining = 2'd0;
            state_a.code_point_acc  = '0;
         end else begin
            state_a.code_point_acc  = acc_shift;
            state_a.bytes_remaining = state_cur.bytes_remaining - 2'd1;
            if (state_cur.bytes_remaining == 2'd1) begin
               emit_en = 1'b1;
               emit_cp = acc_shift;
            end
         end
      end else if (byte_in[7] == 1'b0) begin
         emit_en = 1'b1;
         emit_cp = {13'd0, byte_in};
      end else if (byte_in[7:5] == 3'b110) begin
         state_a.code_point_acc  = {16'd0, byte_in[4:0]};
         state_a.bytes_remaining = 2'd1;
      end else if (byte_in[7:4] == 4'b1110) begin
         state_a.code_point_acc  = {17'd0, byte_in[3:0]};
         state_a.bytes_remaining = 2'd2;
      end else if (byte_in[7:3] == 5'b11110) begin
         state_a.code_point_acc  = {18'd0, byte_in[2:0]};
         state_a.bytes_remaining = 2'd3;
      end else begin
         state_a.error_status    = ST_MALFORMED;
         state_a.bytes_remaining = 2'd0;
         state_a.code_point_acc  = '0;
      end
   end

   // Unit generation with capacity check
   always_comb begin
      state_nxt     = state_a;
      result_count  = (byte_in == 8'h00) ? 2'd1 : 2'd0;
      if (emit_en) begin
         if (emit_cp < SUPPLEMENTARY_BASE) begin
            if (state_cur.units_written >= max_units) begin
               state_nxt.error_status    = ST_OVERFLOW;
               state_nxt.bytes_remaining = 2'd0;
               state_nxt.code_point_acc  = '0;
            end else begin
               result_count                = 2'd1;
               state_nxt.units_written     = state_cur.units_written + 16'd1;
            end
         end else begin
            if (units_plus_two > {1'b0, max_units}) begin
               state_nxt.error_status    = ST_OVERFLOW;
               state_nxt.bytes_remaining = 2'd0;
               state_nxt.code_point_acc  = '0;
            end else begin
               result_count            = 2'd2;
               state_nxt.units_written = units_plus_two[15:0];
            end
         end
      end
   end

   // Payload of emitted units (only used when result_count says so)
   always_comb begin
      emit_first    = '0;
      result_second = '0;
      if (emit_cp < SUPPLEMENTARY_BASE) begin
         emit_first.code_unit     = emit_cp[15:0];
         emit_first.last_of_input = 1'b1;
      end else begin
         emit_first.code_unit = HIGH_SURROGATE + {5'd0, cp_offset[20:10]};
      end
      result_second.code_unit     = LOW_SURROGATE + {6'd0, cp_offset[9:0]};
      result_second.last_of_input = 1'b1;
   end

   // Terminator gives the end result, anything else the first unit
   assign result_first = (byte_in == 8'h00) ? end_result : emit_first;

endmodule

// ===== rtl/u8u16_result_queue.sv =====
`timescale 1ns / 1ps

module u8u16_result_queue import u8u16_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_count,
   input  result_type push_first,
   input  result_type push_second,
   input  logic       pop,
   output logic [1:0] free_slots,
   output logic       head_valid,
   output result_type head
);

   result_type entry_ff [QUEUE_DEPTH];
   result_type entry_in [QUEUE_DEPTH];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic [1:0] after_pop;

   assign after_pop  = count_ff - {1'b0, pop};
   assign free_slots = 2'(QUEUE_DEPTH) - after_pop;
   assign count_in   = after_pop + push_count;
   assign head_valid = (count_ff != 2'd0);
   assign head       = entry_ff[0];

   // Shift on pop, then fill behind the survivors
   always_comb begin
      entry_in = entry_ff;
      if (pop) begin
         entry_in[0] = entry_ff[1];
      end
      if (push_count != 2'd0) begin
         entry_in[after_pop[0]] = push_first;
      end
      if (push_count == 2'd2) begin
         entry_in[1] = push_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/utf8_to_utf16_decoder_core.sv =====
`timescale 1ns / 1ps

// UTF-8 to UTF-16 transcoder.
// req channel: one UTF-8 byte per request (req_byte_in); a zero byte ends the
// string. rsp channel: UTF-16 code units, plus one end result per string
// carrying status (ok, malformed, overflow) and the unit count.
// csr port: max_units at byte address 0 caps the units produced per string.
// A byte accepted on req is held in the input register and decoded from it;
// its results are registered into the result queue when the byte commits,
// and rsp_valid rises when the queue holds them.
// Throughput: one byte per cycle while rsp_ready is high. A surrogate pair
// follows three bytes that produce nothing, so the queue has drained by then
// and the pair does not stall the input. The two-entry result queue is the
// limit: a byte commits only when it has room for all of that byte's results.
// When the receiver stalls, the queue fills and req_ready drops once the byte
// held in the input register cannot commit.
// Reset: clears the queue, the valid flag of the input register and the string
// state, and sets max_units to 255.
module utf8_to_utf16_decoder_core import u8u16_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_last_of_input,
   output logic        rsp_is_end,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_unit_count,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]       byte_ff;
   logic             in_valid_ff;
   logic [15:0]      max_units_ff;
   string_state_type state_ff;
   string_state_type state_nxt;
   logic [1:0]       result_count;
   result_type       result_first;
   result_type       result_second;
   logic [1:0]       free_slots;
   logic             commit;
   logic             pop;
   result_type       head;

   // Register access
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_MAX_UNITS_ADDR) ? {16'd0, max_units_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_units_ff <= MAX_UNITS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr == CSR_MAX_UNITS_ADDR) begin
         max_units_ff <= csr_pwdata[15:0];
      end
   end

   // Decode of the registered byte
   u8u16_decode u_decode (
      .byte_in      (byte_ff),
      .max_units    (max_units_ff),
      .state_cur    (state_ff),
      .state_nxt    (state_nxt),
      .result_count (result_count),
      .result_first (result_first),
      .result_second(result_second)
   );

   assign commit    = in_valid_ff && (free_slots >= result_count);
   assign req_ready = !in_valid_ff || commit;

   // Input register and string state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (commit) begin
            in_valid_ff <= 1'b0;
         end
         if (commit) begin
            state_ff <= state_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_byte_in;
      end
   end

   // Result queue
   assign pop = rsp_valid && rsp_ready;

   u8u16_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (commit ? result_count : 2'd0),
      .push_first (result_first),
      .push_second(result_second),
      .pop        (pop),
      .free_slots (free_slots),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign rsp_code_unit     = head.code_unit;
   assign rsp_last_of_input = head.last_of_input;
   assign rsp_is_end        = head.is_end;
   assign rsp_status        = head.status;
   assign rsp_unit_count    = head.unit_count;

endmodule

// ===== rtl/u8u16_checker.sv =====
`timescale 1ns / 1ps

module u8u16_checker import u8u16_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_code_unit,
   input logic        rsp_last_of_input,
   input logic        rsp_is_end,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_unit_count
);

   // End results close their byte and carry no unit
   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_end |-> rsp_last_of_input && rsp_code_unit == 16'd0)
      else $error("end result with unit or without last flag");

   // Unit results carry no status or count
   a_unit_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_end |-> rsp_status == ST_OK && rsp_unit_count == 16'd0)
      else $error("unit result with status or count");

   // Failed strings report no count
   a_err_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_end && rsp_status != ST_OK |-> rsp_unit_count == 16'd0)
      else $error("count reported on failed string");

   // A unit not last of its byte is a high surrogate followed by a low one
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_input
      |=> rsp_valid && rsp_last_of_input && !rsp_is_end
          && rsp_code_unit[15:10] == 6'b110111)
      else $error("surrogate pair broken");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_unit) && $stable(rsp_is_end))
      else $error("stalled result changed");

endmodule

bind utf8_to_utf16_decoder_core u8u16_checker u_checker (.*);
